[design/rrht_pkg.sv]
// Shared types and constants for the rectangle region hit tester.
// Used by rrht_cell and rect_region_hit_test_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rrht_pkg;

   // Table depth and the width of a fill count that can hold the depth itself.
   localparam int MAX_RECTS = 16;
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);

   // Field widths.
   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int KIND_W  = 4;
   localparam int REQ_W   = 2;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_FIELDS_W = 2 * COORD_W + 2 * SIZE_W + KIND_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + KIND_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_ADD   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_HIT   = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   // One stored rectangle.
   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
      logic [KIND_W-1:0]         kind;
   } rect_type;

   // A hit-test probe walking down the cell chain.
   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic [CNT_W-1:0]          remaining;
      logic                      found;
      logic [KIND_W-1:0]         kind;
   } probe_type;

endpackage

`default_nettype wire

[design/rrht_cell.sv]
// One cell of the rectangle chain: holds one rectangle and tests a passing probe.
// Depends on rrht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrht_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire rrht_pkg::rect_type  rect_in,
   output      rrht_pkg::rect_type  rect_out,
   input  wire rrht_pkg::probe_type probe_in,
   output      rrht_pkg::probe_type probe_out
);
   import rrht_pkg::*;

   rect_type  rect_ff;
   probe_type probe_ff;
   probe_type probe_in_w;

   logic                     active;
   logic signed [COORD_W:0]  dx;
   logic signed [COORD_W:0]  dy;
   logic                     in_x;
   logic                     in_y;
   logic                     hit;

   // The stored rectangle moves one cell down whenever a new one is added.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         rect_ff <= rect_in;
      end
   end

   assign rect_out = rect_ff;

   // Containment with inclusive edges: 0 <= p - edge <= size, in one extra bit.
   always_comb begin
      active = (probe_in.remaining != '0);
      dx     = {probe_in.px[COORD_W-1], probe_in.px} - {rect_ff.left[COORD_W-1], rect_ff.left};
      dy     = {probe_in.py[COORD_W-1], probe_in.py} - {rect_ff.top[COORD_W-1], rect_ff.top};
      in_x   = !dx[COORD_W] && (dx[COORD_W-1:0] <= {1'b0, rect_ff.width});
      in_y   = !dy[COORD_W] && (dy[COORD_W-1:0] <= {1'b0, rect_ff.height});
      hit    = active && !probe_in.found && in_x && in_y;
   end

   // The first hit along the chain wins; later cells only pass the probe on.
   always_comb begin
      probe_in_w           = probe_in;
      probe_in_w.remaining = active ? probe_in.remaining - 1'b1 : '0;
      if (hit) begin
         probe_in_w.found = 1'b1;
         probe_in_w.kind  = rect_ff.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in_w.valid;
      end
      probe_ff.px        <= probe_in_w.px;
      probe_ff.py        <= probe_in_w.py;
      probe_ff.remaining <= probe_in_w.remaining;
      probe_ff.found     <= probe_in_w.found;
      probe_ff.kind      <= probe_in_w.kind;
   end

   assign probe_out = probe_ff;

endmodule

`default_nettype wire

[design/rect_region_hit_test_core.sv]
// Top level of the rectangle region hit tester: request control and the cell chain.
// Depends on rrht_pkg and rrht_cell.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to MAX_RECTS typed rectangles in a row of cells, newest
// in the first cell. An add request shifts the row by one and stores the new
// rectangle in the first cell, or answers status 1 when the table is full; a
// clear request empties the table. Add, clear and the unused code answer in
// the cycle after they are accepted. A hit test sends a probe down the row,
// one cell per cycle, and answers through the output register once the probe
// has left the last cell. The answer is the type of the newest rectangle
// containing the point, edges included, or 0 for no hit. One request is in
// work at a time; a new one is taken only when the output register is empty
// or its result is taken in the same cycle.
module rect_region_hit_test_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // tdata: x_pos[15:0], y_pos[31:16], rect_width[46:32], rect_height[61:47],
   //        region_type[65:62], zero pad up to bit 71.
   input  wire logic [rrht_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: req_type[1:0].
   input  wire logic [rrht_pkg::REQ_W-1:0]       req_tuser,
   // Result channel.
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: status[0], hit_type[4:1], zero pad up to bit 7.
   output      logic [rrht_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import rrht_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type        state_ff;
   logic             rsp_valid_ff;
   logic             status_ff;
   logic [KIND_W-1:0] hit_ff;
   logic [CNT_W-1:0] count_ff;

   rect_type         new_rect;
   rect_type         cell_rect [0:MAX_RECTS-1];
   probe_type        probe_chain [0:MAX_RECTS];
   req_code_type     req_code;
   logic             req_acc;
   logic             table_full;
   logic             do_add;

   // Request decode.
   always_comb begin
      req_code        = req_code_type'(req_tuser);
      new_rect.left   = req_tdata[15:0];
      new_rect.top    = req_tdata[31:16];
      new_rect.width  = req_tdata[46:32];
      new_rect.height = req_tdata[61:47];
      new_rect.kind   = req_tdata[65:62];
      table_full      = (count_ff == CNT_W'(MAX_RECTS));
      req_tready      = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
      req_acc         = req_tvalid && req_tready;
      do_add          = req_acc && (req_code == REQ_ADD) && !table_full;
   end

   // Probe launch into the first cell.
   always_comb begin
      probe_chain[0].valid     = req_acc && (req_code == REQ_HIT);
      probe_chain[0].px        = new_rect.left;
      probe_chain[0].py        = new_rect.top;
      probe_chain[0].remaining = count_ff;
      probe_chain[0].found     = 1'b0;
      probe_chain[0].kind      = '0;
   end

   // The cell chain.
   for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
      rect_type shift_src;
      if (i == 0) begin : g_head
         assign shift_src = new_rect;
      end else begin : g_body
         assign shift_src = cell_rect[i-1];
      end
      rrht_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (do_add),
         .rect_in   (shift_src),
         .rect_out  (cell_rect[i]),
         .probe_in  (probe_chain[i]),
         .probe_out (probe_chain[i+1])
      );
   end

   // Control state, fill count and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  case (req_code)
                     REQ_ADD: begin
                        rsp_valid_ff <= 1'b1;
                        status_ff    <= table_full;
                        hit_ff       <= '0;
                        if (!table_full) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     REQ_CLEAR: begin
                        rsp_valid_ff <= 1'b1;
                        status_ff    <= 1'b0;
                        hit_ff       <= '0;
                        count_ff     <= '0;
                     end
                     REQ_HIT: begin
                        state_ff <= ST_PROBE;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        status_ff    <= 1'b0;
                        hit_ff       <= '0;
                     end
                  endcase
               end
            end
            ST_PROBE: begin
               if (probe_chain[MAX_RECTS].valid) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= 1'b0;
                  hit_ff       <= probe_chain[MAX_RECTS].kind;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), hit_ff, status_ff};

   // The fill count never exceeds the table depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("fill count beyond table depth");

   // A probe leaves the chain only while a hit test is in work.
   assert property (@(posedge clock) disable iff (reset)
      probe_chain[MAX_RECTS].valid |-> (state_ff == ST_PROBE))
      else $error("probe left the chain outside a hit test");

   // The output register is free when a probe result arrives.
   assert property (@(posedge clock) disable iff (reset)
      probe_chain[MAX_RECTS].valid |-> !rsp_valid_ff)
      else $error("probe result would overwrite a pending result");

   // An add to a full table leaves the count alone and reports full.
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_code == REQ_ADD) && table_full) |=> (table_full && status_ff))
      else $error("add to a full table was not refused");

endmodule

`default_nettype wire
